// ===== design/hpfe_pkg.sv =====
// Shared types, constants and helpers for the hysteresis peak feature extractor.
package hpfe_pkg;

  // Field widths
  localparam int SAMPLE_W = 8;
  localparam int SUM_W    = 12;
  localparam int TIMER_W  = 14;
  localparam int COUNT_W  = 10;
  localparam int SLOT_W   = 3;
  localparam int EVENT_W  = 2;

  // Each window term is sample * SCALE / window length
  localparam int SCALE = 10;

  // Hysteresis ratios: upper = 12/10, lower = 8/10 of the long sum
  localparam int UP_NUM  = 6;
  localparam int UP_DEN  = 5;
  localparam int LO_NUM  = 4;
  localparam int LO_DEN  = 5;

  localparam logic [TIMER_W-1:0] TIMER_MAX    = TIMER_W'(10000);
  localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
  localparam logic [SUM_W-1:0]   THRESH_RESET = SUM_W'(400);

  // Result event codes
  localparam logic [EVENT_W-1:0] EV_NONE  = 2'd0;
  localparam logic [EVENT_W-1:0] EV_OPEN  = 2'd1;
  localparam logic [EVENT_W-1:0] EV_CLOSE = 2'd2;

  // Window stage to peak stage hand-off
  typedef struct packed {
    logic             valid;
    logic             clear;
    logic [SUM_W-1:0] short_sum;
    logic [SUM_W-1:0] long_sum;
  } win_t;

  // Saturating timer increment
  function automatic logic [TIMER_W-1:0] tick(input logic [TIMER_W-1:0] t);
    return (t < TIMER_MAX) ? t + TIMER_W'(1) : t;
  endfunction

endpackage

// ===== design/hpfe_cell.sv =====
// One sample cell of the delay line: holds a sample and passes it on.
module hpfe_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic [hpfe_pkg::SAMPLE_W-1:0] d_i,
  output logic [hpfe_pkg::SAMPLE_W-1:0] q_o
);
  import hpfe_pkg::*;

  logic [SAMPLE_W-1:0] data_q;

  // Shift on every sample transaction; line starts all zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else if (en_i) begin
      data_q <= d_i;
    end
  end

  assign q_o = data_q;

endmodule

// ===== design/hpfe_window.sv =====
// Sample delay line of cells and the short and long running sums.
module hpfe_window #(
  parameter int LONG_WINDOW  = 200,
  parameter int SHORT_WINDOW = 60
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          func_i,
  input  logic [hpfe_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                          take_i,
  output logic                          ready_o,
  output hpfe_pkg::win_t                win_o
);
  import hpfe_pkg::*;

  localparam int RING_SIZE = LONG_WINDOW + 1;
  localparam int SHORT_TAP = SHORT_WINDOW % RING_SIZE;
  localparam int TAB_N     = 2 ** SAMPLE_W;

  logic                valid_q, valid_d;
  logic                clear_q, clear_d;
  logic [SUM_W-1:0]    short_q, short_d;
  logic [SUM_W-1:0]    long_q, long_d;
  logic                accept;
  logic                shift_en;

  // line[0] is the incoming sample, line[j] the one j samples back
  logic [SAMPLE_W-1:0] line [LONG_WINDOW+1];

  // Per-sample terms, worked out at elaboration
  logic [SUM_W-1:0]    short_tab [TAB_N];
  logic [SUM_W-1:0]    long_tab  [TAB_N];

  logic [SUM_W:0]      short_ext, long_ext;
  logic [SUM_W-1:0]    short_old, long_old;

  assign ready_o  = !valid_q || take_i;
  assign accept   = in_valid_i && ready_o;
  assign shift_en = accept && !func_i;

  for (genvar g = 0; g < TAB_N; g++) begin : g_tab
    assign short_tab[g] = SUM_W'((g * SCALE) / SHORT_WINDOW);
    assign long_tab[g]  = SUM_W'((g * SCALE) / LONG_WINDOW);
  end

  // Delay line
  assign line[0] = sample_i;
  for (genvar j = 0; j < LONG_WINDOW; j++) begin : g_cell
    hpfe_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (shift_en),
      .d_i    (line[j]),
      .q_o    (line[j+1])
    );
  end

  // Running sums: add the new term, drop the oldest, floor at zero
  always_comb begin
    short_old = short_tab[line[SHORT_TAP]];
    long_old  = long_tab[line[LONG_WINDOW]];
    short_ext = (SUM_W+1)'(short_q) + (SUM_W+1)'(short_tab[sample_i]);
    long_ext  = (SUM_W+1)'(long_q) + (SUM_W+1)'(long_tab[sample_i]);

    short_d = short_q;
    long_d  = long_q;
    if (shift_en) begin
      short_d = (short_ext > (SUM_W+1)'(short_old)) ?
                SUM_W'(short_ext - (SUM_W+1)'(short_old)) : '0;
      long_d  = (long_ext > (SUM_W+1)'(long_old)) ?
                SUM_W'(long_ext - (SUM_W+1)'(long_old)) : '0;
    end

    valid_d = valid_q;
    clear_d = clear_q;
    if (accept) begin
      valid_d = 1'b1;
      clear_d = func_i;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      clear_q <= 1'b0;
      short_q <= '0;
      long_q  <= '0;
    end else begin
      valid_q <= valid_d;
      clear_q <= clear_d;
      short_q <= short_d;
      long_q  <= long_d;
    end
  end

  // Sums stay put until the next sample, so they travel with the held transaction
  assign win_o.valid     = valid_q;
  assign win_o.clear     = clear_q;
  assign win_o.short_sum = short_q;
  assign win_o.long_sum  = long_q;

endmodule

// ===== design/hpfe_peak.sv =====
// Hysteresis peak tracker, feature timers and the result register.
module hpfe_peak #(
  parameter int HISTORY_DEPTH = 6
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  hpfe_pkg::win_t               win_i,
  input  logic [hpfe_pkg::SUM_W-1:0]   thresh_i,
  output logic                         take_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [hpfe_pkg::SUM_W-1:0]   smoothed_o,
  output logic                         above_o,
  output logic [hpfe_pkg::COUNT_W-1:0] peak_total_o,
  output logic [hpfe_pkg::EVENT_W-1:0] event_res_o,
  output logic [hpfe_pkg::SLOT_W-1:0]  slot_o,
  output logic [hpfe_pkg::SUM_W-1:0]   peak_height_o,
  output logic [hpfe_pkg::TIMER_W-1:0] peak_rise_o,
  output logic [hpfe_pkg::TIMER_W-1:0] peak_width_o,
  output logic [hpfe_pkg::TIMER_W-1:0] valley_width_o,
  output logic [hpfe_pkg::TIMER_W-1:0] signal_width_o
);
  import hpfe_pkg::*;

  localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(HISTORY_DEPTH - 1);
  localparam int CMP_W = SUM_W + 4;

  // Peak state
  logic                inside_q, inside_d;
  logic [COUNT_W-1:0]  cnt_q, cnt_d;
  logic [PTR_W-1:0]    ptr_q, ptr_d;
  logic [SUM_W-1:0]    hgt_q  [HISTORY_DEPTH];
  logic [SUM_W-1:0]    hgt_d  [HISTORY_DEPTH];
  logic [TIMER_W-1:0]  rise_q [HISTORY_DEPTH];
  logic [TIMER_W-1:0]  rise_d [HISTORY_DEPTH];
  logic [TIMER_W-1:0]  wt_q, wt_d, vt_q, vt_d, rt_q, rt_d, gt_q, gt_d;

  // Result register
  logic                out_valid_q, out_valid_d;
  logic [SUM_W-1:0]    smoothed_q;
  logic                above_q;
  logic [COUNT_W-1:0]  total_q;
  logic [EVENT_W-1:0]  event_q, event_d;
  logic [PTR_W-1:0]    slot_q;
  logic [SUM_W-1:0]    height_q;
  logic [TIMER_W-1:0]  prise_q;
  logic [TIMER_W-1:0]  pwidth_q, pwidth_d;
  logic [TIMER_W-1:0]  vwidth_q, vwidth_d;
  logic [TIMER_W-1:0]  swidth_q;

  logic [SUM_W-1:0]    s_sum, l_sum;
  logic [CMP_W-1:0]    s_up, l_up, s_lo, l_lo;
  logic                open_pk, below_lo;

  assign take_o = win_i.valid && (!out_valid_q || !out_stall_i);
  assign s_sum  = win_i.short_sum;
  assign l_sum  = win_i.long_sum;

  // Level tests without division: S > 12L/10 iff 5S > 6L, S < 8L/10 iff 5(S+1) <= 4L
  always_comb begin
    s_up     = CMP_W'(s_sum) * CMP_W'(UP_DEN);
    l_up     = CMP_W'(l_sum) * CMP_W'(UP_NUM);
    s_lo     = (CMP_W'(s_sum) + CMP_W'(1)) * CMP_W'(LO_DEN);
    l_lo     = CMP_W'(l_sum) * CMP_W'(LO_NUM);
    open_pk  = !win_i.clear && !inside_q && (s_sum > thresh_i) && (s_up > l_up);
    below_lo = (s_lo <= l_lo);
  end

  // Next peak state for the transaction being taken
  always_comb begin
    inside_d = inside_q;
    cnt_d    = cnt_q;
    ptr_d    = ptr_q;
    hgt_d    = hgt_q;
    rise_d   = rise_q;
    wt_d     = wt_q;
    vt_d     = vt_q;
    rt_d     = rt_q;
    gt_d     = gt_q;
    event_d  = EV_NONE;
    pwidth_d = '0;
    vwidth_d = '0;

    if (win_i.clear) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hgt_d[i]  = '0;
        rise_d[i] = '0;
      end
      cnt_d    = '0;
      ptr_d    = '0;
      inside_d = 1'b0;
    end else begin
      // Peak opens
      if (open_pk) begin
        inside_d = 1'b1;
        event_d  = EV_OPEN;
        if (cnt_q == '0) begin
          gt_d  = '0;
          ptr_d = '0;
        end else begin
          vwidth_d = vt_q;
        end
        if (cnt_q != COUNT_MAX) begin
          cnt_d = cnt_q + COUNT_W'(1);
          if (cnt_q != '0) begin
            ptr_d = (ptr_q == PTR_LAST) ? '0 : ptr_q + PTR_W'(1);
          end
        end
        wt_d = '0;
        rt_d = '0;
      end

      // Inside a peak: track the maximum, check for the close
      if (inside_d) begin
        if (hgt_q[ptr_d] < s_sum) begin
          hgt_d[ptr_d]  = s_sum;
          rise_d[ptr_d] = rt_d;
        end
        if (below_lo) begin
          inside_d = 1'b0;
          vt_d     = '0;
          pwidth_d = wt_d;
          event_d  = EV_CLOSE;
        end
      end

      wt_d = tick(wt_d);
      gt_d = tick(gt_d);
      vt_d = tick(vt_d);
      rt_d = tick(rt_d);
    end

    out_valid_d = out_valid_q;
    if (take_o) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      inside_q    <= 1'b0;
      cnt_q       <= '0;
      ptr_q       <= '0;
      wt_q        <= '0;
      vt_q        <= '0;
      rt_q        <= '0;
      gt_q        <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hgt_q[i]  <= '0;
        rise_q[i] <= '0;
      end
    end else begin
      out_valid_q <= out_valid_d;
      if (take_o) begin
        inside_q <= inside_d;
        cnt_q    <= cnt_d;
        ptr_q    <= ptr_d;
        wt_q     <= wt_d;
        vt_q     <= vt_d;
        rt_q     <= rt_d;
        gt_q     <= gt_d;
        hgt_q    <= hgt_d;
        rise_q   <= rise_d;
      end
    end
  end

  // Result payload, loaded with each taken transaction
  always_ff @(posedge clk_i) begin
    if (take_o) begin
      smoothed_q <= s_sum;
      above_q    <= inside_d;
      total_q    <= cnt_d;
      event_q    <= event_d;
      slot_q     <= ptr_d;
      height_q   <= hgt_d[ptr_d];
      prise_q    <= rise_d[ptr_d];
      pwidth_q   <= pwidth_d;
      vwidth_q   <= vwidth_d;
      swidth_q   <= gt_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign smoothed_o     = smoothed_q;
  assign above_o        = above_q;
  assign peak_total_o   = total_q;
  assign event_res_o    = event_q;
  assign slot_o         = SLOT_W'(slot_q);
  assign peak_height_o  = height_q;
  assign peak_rise_o    = prise_q;
  assign peak_width_o   = pwidth_q;
  assign valley_width_o = vwidth_q;
  assign signal_width_o = swidth_q;

endmodule

// ===== design/hysteresis_peak_feature_extractor_top.sv =====
// Top level of the hysteresis peak feature extractor.
//
// Input channel: in_valid_i / in_stall_o with func_i and sample_i. A sample
// transaction (func 0) shifts the sample into a line of LONG_WINDOW cells and
// updates the short and long running sums; a clear transaction (func 1) wipes
// the peak history, peak count and hysteresis flag.
// Output channel: out_valid_o / out_stall_i, one result per input transaction,
// in order.
// Result path: each input transaction passes the sum register, then the peak
// stage that loads the output register. Throughput: one transaction per
// cycle unless the receiver stalls; the peak stage closes its state loop
// combinationally, so nothing else limits the rate. Receiver stall: the
// output register holds its result; the sum stage keeps accepting until it
// holds one transaction, then in_stall_o rises. Reset (asynchronous, active
// low): cells, sums, peak history, timers and counters clear to zero at once
// and the threshold returns to 400; no clearing pass is needed. The user must
// write the threshold (cfg_we_i) only while idle; the block does not check.
module hysteresis_peak_feature_extractor_top #(
  parameter int LONG_WINDOW   = 200,
  parameter int SHORT_WINDOW  = 60,
  parameter int HISTORY_DEPTH = 6
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [hpfe_pkg::SUM_W-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         func_i,
  input  logic [hpfe_pkg::SAMPLE_W-1:0] sample_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [hpfe_pkg::SUM_W-1:0]   smoothed_o,
  output logic                         above_o,
  output logic [hpfe_pkg::COUNT_W-1:0] peak_total_o,
  output logic [hpfe_pkg::EVENT_W-1:0] event_res_o,
  output logic [hpfe_pkg::SLOT_W-1:0]  slot_o,
  output logic [hpfe_pkg::SUM_W-1:0]   peak_height_o,
  output logic [hpfe_pkg::TIMER_W-1:0] peak_rise_o,
  output logic [hpfe_pkg::TIMER_W-1:0] peak_width_o,
  output logic [hpfe_pkg::TIMER_W-1:0] valley_width_o,
  output logic [hpfe_pkg::TIMER_W-1:0] signal_width_o
);
  import hpfe_pkg::*;

  logic [SUM_W-1:0] thresh_q;
  logic             win_ready;
  logic             take;
  win_t             win;

  // Level threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RESET;
    end else if (cfg_we_i) begin
      thresh_q <= cfg_wdata_i;
    end
  end

  assign in_stall_o = !win_ready;

  hpfe_window #(
    .LONG_WINDOW  (LONG_WINDOW),
    .SHORT_WINDOW (SHORT_WINDOW)
  ) u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .sample_i   (sample_i),
    .take_i     (take),
    .ready_o    (win_ready),
    .win_o      (win)
  );

  hpfe_peak #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_peak (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .win_i          (win),
    .thresh_i       (thresh_q),
    .take_o         (take),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .smoothed_o     (smoothed_o),
    .above_o        (above_o),
    .peak_total_o   (peak_total_o),
    .event_res_o    (event_res_o),
    .slot_o         (slot_o),
    .peak_height_o  (peak_height_o),
    .peak_rise_o    (peak_rise_o),
    .peak_width_o   (peak_width_o),
    .valley_width_o (valley_width_o),
    .signal_width_o (signal_width_o)
  );

endmodule

// ===== test/hysteresis_peak_feature_extractor_top_tb.sv =====
// Self-checking testbench for the hysteresis peak feature extractor top level.
module hysteresis_peak_feature_extractor_top_tb;
  import hpfe_pkg::*;

  localparam int LONG_LEN    = 200;
  localparam int SHORT_LEN   = 60;
  localparam int SLOTS       = 6;
  localparam int RING_LEN    = LONG_LEN + 1;
  localparam int TIMER_CAP   = 10000;
  localparam int COUNT_CAP   = 1023;
  localparam int PHASE_ITEMS = 200;
  localparam int MAX_SHOWN   = 10;

  typedef struct packed {
    logic [SUM_W-1:0]   smoothed;
    logic               above;
    logic [COUNT_W-1:0] peak_total;
    logic [EVENT_W-1:0] event_res;
    logic [SLOT_W-1:0]  slot;
    logic [SUM_W-1:0]   peak_height;
    logic [TIMER_W-1:0] peak_rise;
    logic [TIMER_W-1:0] peak_width;
    logic [TIMER_W-1:0] valley_width;
    logic [TIMER_W-1:0] signal_width;
  } feature_t;

  // Block inputs, known from time zero
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [SUM_W-1:0]    cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                func_i      = 1'b0;
  logic [SAMPLE_W-1:0] sample_i    = '0;
  logic                out_stall_i = 1'b0;

  logic                in_stall_o;
  logic                out_valid_o;
  logic [SUM_W-1:0]    smoothed_o;
  logic                above_o;
  logic [COUNT_W-1:0]  peak_total_o;
  logic [EVENT_W-1:0]  event_res_o;
  logic [SLOT_W-1:0]   slot_o;
  logic [SUM_W-1:0]    peak_height_o;
  logic [TIMER_W-1:0]  peak_rise_o;
  logic [TIMER_W-1:0]  peak_width_o;
  logic [TIMER_W-1:0]  valley_width_o;
  logic [TIMER_W-1:0]  signal_width_o;

  hysteresis_peak_feature_extractor_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .sample_i       (sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .smoothed_o     (smoothed_o),
    .above_o        (above_o),
    .peak_total_o   (peak_total_o),
    .event_res_o    (event_res_o),
    .slot_o         (slot_o),
    .peak_height_o  (peak_height_o),
    .peak_rise_o    (peak_rise_o),
    .peak_width_o   (peak_width_o),
    .valley_width_o (valley_width_o),
    .signal_width_o (signal_width_o)
  );

  // Predictor state
  logic [SAMPLE_W-1:0] ring_mem [RING_LEN];
  int                  height_mem [SLOTS];
  int                  rise_mem [SLOTS];
  int                  wr_pos, short_acc, long_acc;
  bit                  in_peak;
  int                  peaks, slot_ptr;
  int                  width_t, valley_t, rise_t, gesture_t;
  logic [SUM_W-1:0]    level_thr;

  feature_t expected_features[$];
  int       idle_pct, stall_pct;
  int       mismatch_count, result_count;
  int       open_count, close_count, clear_count;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver stall, redrawn every cycle
  always @(posedge clk_i) begin
    out_stall_i <= rst_ni && ($urandom_range(99) < stall_pct);
  end

  function automatic int floor_diff(input int a, input int b);
    return (a > b) ? a - b : 0;
  endfunction

  function automatic int bump(input int t);
    return (t < TIMER_CAP) ? t + 1 : t;
  endfunction

  function automatic string show(input feature_t f);
    return $sformatf({"smoothed=%0d above=%0d total=%0d event=%0d slot=%0d height=%0d",
                      " rise=%0d width=%0d valley=%0d signal=%0d"},
                     f.smoothed, f.above, f.peak_total, f.event_res, f.slot,
                     f.peak_height, f.peak_rise, f.peak_width, f.valley_width,
                     f.signal_width);
  endfunction

  // Advance the predictor by one transaction and return the result it implies
  function automatic feature_t predict_features(input logic clear,
                                                input logic [SAMPLE_W-1:0] smp);
    feature_t           r;
    logic [EVENT_W-1:0] ev;
    int                 pos, old_s, old_l, upper, lower, pw, vw, s;
    ev = EV_NONE;
    pw = 0;
    vw = 0;
    if (clear) begin
      // history, count and flag only; ring, sums and timers are kept
      for (int i = 0; i < SLOTS; i++) begin
        height_mem[i] = 0;
        rise_mem[i] = 0;
      end
      peaks = 0;
      slot_ptr = 0;
      in_peak = 1'b0;
      clear_count++;
    end else begin
      s = smp;
      pos = wr_pos;
      old_s = (pos + RING_LEN - SHORT_LEN) % RING_LEN;
      old_l = (pos + 1) % RING_LEN;
      ring_mem[pos] = smp;
      short_acc = floor_diff(short_acc + s * 10 / SHORT_LEN,
                             int'(ring_mem[old_s]) * 10 / SHORT_LEN);
      long_acc = floor_diff(long_acc + s * 10 / LONG_LEN,
                            int'(ring_mem[old_l]) * 10 / LONG_LEN);
      upper = 12 * long_acc / 10;
      lower = 8 * long_acc / 10;

      // peak opening
      if (short_acc > level_thr && !in_peak && short_acc > upper) begin
        in_peak = 1'b1;
        ev = EV_OPEN;
        open_count++;
        if (peaks == 0) gesture_t = 0;
        else vw = valley_t;
        if (peaks < COUNT_CAP) peaks++;
        slot_ptr = (peaks - 1) % SLOTS;
        width_t = 0;
        rise_t = 0;
      end

      // height tracking and closing
      if (in_peak) begin
        if (height_mem[slot_ptr] < short_acc) begin
          height_mem[slot_ptr] = short_acc;
          rise_mem[slot_ptr] = rise_t;
        end
        if (short_acc < lower) begin
          in_peak = 1'b0;
          valley_t = 0;
          pw = width_t;
          ev = EV_CLOSE;
          close_count++;
        end
      end

      width_t = bump(width_t);
      gesture_t = bump(gesture_t);
      valley_t = bump(valley_t);
      rise_t = bump(rise_t);
      wr_pos = (pos + 1) % RING_LEN;
    end

    r.smoothed     = SUM_W'(short_acc);
    r.above        = in_peak;
    r.peak_total   = COUNT_W'(peaks);
    r.event_res    = ev;
    r.slot         = SLOT_W'(slot_ptr);
    r.peak_height  = SUM_W'(height_mem[slot_ptr]);
    r.peak_rise    = TIMER_W'(rise_mem[slot_ptr]);
    r.peak_width   = TIMER_W'(pw);
    r.valley_width = TIMER_W'(vw);
    r.signal_width = TIMER_W'(gesture_t);
    return r;
  endfunction

  // Result checker: every accepted result against the oldest expectation
  always @(posedge clk_i) begin
    feature_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{smoothed_o, above_o, peak_total_o, event_res_o, slot_o, peak_height_o,
              peak_rise_o, peak_width_o, valley_width_o, signal_width_o};
      result_count++;
      if (expected_features.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
          $display("ERROR: unexpected result %s", show(got));
      end else begin
        want = expected_features.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= MAX_SHOWN) begin
            $display("ERROR: result %0d mismatch", result_count);
            $display("  expected %s", show(want));
            $display("  actual   %s", show(got));
          end
        end
      end
    end
  end

  // One input transaction, then an optional sender gap
  task automatic send_item(input logic clear, input logic [SAMPLE_W-1:0] smp);
    in_valid_i <= 1'b1;
    func_i     <= clear;
    sample_i   <= smp;
    do @(posedge clk_i); while (in_stall_o);
    expected_features.push_back(predict_features(clear, smp));
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic send_run(input int n, input int lo, input int hi);
    repeat (n) send_item(1'b0, SAMPLE_W'($urandom_range(lo, hi)));
  endtask

  // Sender holds off until every outstanding result is back
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (expected_features.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [SUM_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    level_thr = value;
  endtask

  // Field extremes, clear with no peak, clear inside a peak, reopen after clear
  task automatic test_directed_edges();
    send_item(1'b1, 8'hFF);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    wait_for_results();
    repeat (12) send_item(1'b0, 8'hFF);
    send_item(1'b1, 8'h00);
    repeat (3) send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'h80);
    send_item(1'b0, 8'h01);
  endtask

  // Full-scale level sits exactly at the top threshold, one below it opens
  task automatic test_threshold_ceiling();
    send_item(1'b1, SAMPLE_W'($urandom_range(0, 255)));
    wait_for_results();
    write_threshold(SUM_W'(2520));
    send_run(62, 255, 255);
    wait_for_results();
    write_threshold(SUM_W'(2519));
    send_run(1, 255, 255);
    send_run(70, 0, 0);
  endtask

  // Random gestures over four handshake pressure phases
  task automatic test_random_gestures();
    int idle_set[4]  = '{0, 84, 0, 22};
    int stall_set[4] = '{0, 0, 84, 22};
    int kind, n, sent;
    logic [SUM_W-1:0] thr;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       thr = SUM_W'($urandom_range(300, 800));
        1:       thr = '0;
        2:       thr = SUM_W'($urandom_range(0, 2520));
        default: thr = SUM_W'($urandom_range(200, 1200));
      endcase
      wait_for_results();
      write_threshold(thr);
      idle_pct = idle_set[ph];
      stall_pct = stall_set[ph];
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        kind = $urandom_range(99);
        if (kind < 70) begin
          // quiet valley, then a burst
          n = $urandom_range(20, 90);
          send_run(n, 0, 40);
          sent += n;
          n = $urandom_range(5, 70);
          send_run(n, 120, 255);
          sent += n;
        end else if (kind < 82) begin
          // noise with stray clears
          n = $urandom_range(1, 30);
          repeat (n)
            send_item($urandom_range(9) == 0, SAMPLE_W'($urandom_range(0, 255)));
          sent += n;
        end else if (kind < 88) begin
          send_item(1'b1, SAMPLE_W'($urandom_range(0, 255)));
          sent++;
        end else begin
          // truncated burst, sometimes cut by a clear
          n = $urandom_range(1, 6);
          send_run(n, 150, 255);
          if ($urandom_range(1)) send_item(1'b1, SAMPLE_W'($urandom_range(0, 255)));
          send_run(10, 0, 20);
          sent += n + 11;
        end
      end
    end
    idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    for (int i = 0; i < RING_LEN; i++) ring_mem[i] = '0;
    for (int i = 0; i < SLOTS; i++) begin
      height_mem[i] = 0;
      rise_mem[i] = 0;
    end
    wr_pos = 0;
    short_acc = 0;
    long_acc = 0;
    in_peak = 1'b0;
    peaks = 0;
    slot_ptr = 0;
    width_t = 0;
    valley_t = 0;
    rise_t = 0;
    gesture_t = 0;
    level_thr = THRESH_RESET;
    idle_pct = 0;
    stall_pct = 0;
    mismatch_count = 0;
    result_count = 0;
    open_count = 0;
    close_count = 0;
    clear_count = 0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_edges();
    test_threshold_ceiling();
    test_random_gestures();

    wait_for_results();
    repeat (8) @(posedge clk_i);
    $display("Checked %0d results: %0d peaks opened, %0d closed, %0d clear transactions,",
             result_count, open_count, close_count, clear_count);
    $display("thresholds 0 to 2520, clears inside and outside peaks, four stall mixes");
    if (mismatch_count == 0 && expected_features.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_count,
               expected_features.size());
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(10 * 5000000);
    $display("Timeout with %0d results outstanding", expected_features.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
